>>> hw/rtl/cle_pkg.sv
// Package for the load and add/subtract execute core.
// Holds register indexes, opcode constants, the ALU operation codes and shared types.
// No dependencies; the other files that use it refer to it by scoped names.
package cle_pkg;

  localparam int unsigned NUM_REGS = 7;

  localparam logic [2:0] IDX_H    = 3'd4;
  localparam logic [2:0] IDX_L    = 3'd5;
  localparam logic [2:0] IDX_A    = 3'd6;
  localparam logic [2:0] OPND_MEM = 3'd6;
  localparam logic [2:0] OPND_A   = 3'd7;

  localparam logic [7:0] OP_HALT = 8'h76;
  localparam logic [1:0] GRP_LD  = 2'b01;
  localparam logic [2:0] GRP_ALU = 3'b100;

  localparam logic [3:0] FLAG_Z = 4'h8;
  localparam logic [3:0] FLAG_N = 4'h4;
  localparam logic [3:0] FLAG_H = 4'h2;
  localparam logic [3:0] FLAG_C = 4'h1;

  typedef enum logic [1:0] {
    ALU_ADD = 2'b00,
    ALU_ADC = 2'b01,
    ALU_SUB = 2'b10,
    ALU_SBC = 2'b11
  } alu_op_t;

  typedef logic [NUM_REGS-1:0][7:0] regs_t;

  typedef struct packed {
    logic       reg_we;
    logic [2:0] reg_idx;
    logic [7:0] reg_data;
    logic       flag_we;
    logic [3:0] flags;
  } wr_t;

  typedef struct packed {
    logic        mem_write;
    logic [15:0] mem_address;
    logic [7:0]  mem_write_data;
    logic [7:0]  acc_value;
    logic [3:0]  flag_bits;
    logic [15:0] pair_hl_after;
  } result_t;

  // Operand index to register slot: A is operand 7 but slot 6.
  function automatic logic [2:0] slot_of(input logic [2:0] sel);
    slot_of = (sel == OPND_A) ? IDX_A : sel;
  endfunction

endpackage

>>> hw/rtl/cle_if.sv
// Channel interfaces for the execute core: input items and result items.
// Does not depend on cle_pkg.
interface cle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] opcode;
  logic [7:0] mem_byte;
  modport source (output valid, output opcode, output mem_byte, input ready);
  modport sink (input valid, input opcode, input mem_byte, output ready);
endinterface

interface cle_out_if;
  logic        valid;
  logic        ready;
  logic        mem_write;
  logic [15:0] mem_address;
  logic [7:0]  mem_write_data;
  logic [7:0]  acc_value;
  logic [3:0]  flag_bits;
  logic [15:0] pair_hl_after;
  modport source (output valid, output mem_write, output mem_address, output mem_write_data,
                  output acc_value, output flag_bits, output pair_hl_after, input ready);
  modport sink (input valid, input mem_write, input mem_address, input mem_write_data,
                input acc_value, input flag_bits, input pair_hl_after, output ready);
endinterface

>>> hw/rtl/cle_exec.sv
// Decode and ALU for one opcode: register file writes and the result item.
// Purely combinational; depends on cle_pkg.
module cle_exec (
  input  logic [7:0]      opcode,
  input  logic [7:0]      mem_byte,
  input  cle_pkg::regs_t  regs,
  input  logic [3:0]      flags,
  output cle_pkg::wr_t    wr,
  output cle_pkg::result_t res
);

  logic [2:0]  dst;
  logic [2:0]  src;
  logic [7:0]  src_val;
  logic        is_ld;
  logic        is_alu;
  logic [1:0]  alu_op;
  logic        cin;
  logic [4:0]  half_sum;
  logic [8:0]  full_sum;
  logic [4:0]  half_sub;
  logic [8:0]  full_sub;
  logic [7:0]  alu_res;
  logic [3:0]  alu_flags;
  logic [7:0]  a_after;
  logic [7:0]  h_after;
  logic [7:0]  l_after;

  assign dst     = opcode[5:3];
  assign src     = opcode[2:0];
  assign src_val = (src == cle_pkg::OPND_MEM) ? mem_byte : regs[cle_pkg::slot_of(src)];
  assign is_ld   = (opcode[7:6] == cle_pkg::GRP_LD) && (opcode != cle_pkg::OP_HALT);
  assign is_alu  = (opcode[7:5] == cle_pkg::GRP_ALU);
  assign alu_op  = opcode[4:3];
  assign cin     = alu_op[0] & flags[0];

  assign half_sum = {1'b0, regs[cle_pkg::IDX_A][3:0]} + {1'b0, src_val[3:0]} + {4'd0, cin};
  assign full_sum = {1'b0, regs[cle_pkg::IDX_A]} + {1'b0, src_val} + {8'd0, cin};
  assign half_sub = {1'b0, src_val[3:0]} + {4'd0, cin};
  assign full_sub = {1'b0, src_val} + {8'd0, cin};

  always_comb begin
    alu_flags = 4'h0;
    unique case (alu_op)
      cle_pkg::ALU_ADD, cle_pkg::ALU_ADC: begin
        alu_res = full_sum[7:0];
        if (half_sum[4]) alu_flags = alu_flags | cle_pkg::FLAG_H;
        if (full_sum[8]) alu_flags = alu_flags | cle_pkg::FLAG_C;
      end
      default: begin
        alu_res   = regs[cle_pkg::IDX_A] - full_sub[7:0];
        alu_flags = alu_flags | cle_pkg::FLAG_N;
        if ({1'b0, regs[cle_pkg::IDX_A][3:0]} < half_sub) begin
          alu_flags = alu_flags | cle_pkg::FLAG_H;
        end
        if ({1'b0, regs[cle_pkg::IDX_A]} < full_sub) begin
          alu_flags = alu_flags | cle_pkg::FLAG_C;
        end
      end
    endcase
    if (alu_res == 8'd0) alu_flags = alu_flags | cle_pkg::FLAG_Z;
  end

  always_comb begin
    wr.reg_we   = 1'b0;
    wr.reg_idx  = cle_pkg::slot_of(dst);
    wr.reg_data = src_val;
    wr.flag_we  = 1'b0;
    wr.flags    = alu_flags;
    if (is_ld && (dst != cle_pkg::OPND_MEM)) begin
      wr.reg_we = 1'b1;
    end else if (is_alu) begin
      wr.reg_we   = 1'b1;
      wr.reg_idx  = cle_pkg::IDX_A;
      wr.reg_data = alu_res;
      wr.flag_we  = 1'b1;
    end
  end

  assign a_after = (wr.reg_we && wr.reg_idx == cle_pkg::IDX_A) ? wr.reg_data
                                                               : regs[cle_pkg::IDX_A];
  assign h_after = (wr.reg_we && wr.reg_idx == cle_pkg::IDX_H) ? wr.reg_data
                                                               : regs[cle_pkg::IDX_H];
  assign l_after = (wr.reg_we && wr.reg_idx == cle_pkg::IDX_L) ? wr.reg_data
                                                               : regs[cle_pkg::IDX_L];

  always_comb begin
    res.mem_write      = is_ld && (dst == cle_pkg::OPND_MEM);
    res.mem_address    = {regs[cle_pkg::IDX_H], regs[cle_pkg::IDX_L]};
    res.mem_write_data = res.mem_write ? src_val : 8'd0;
    res.acc_value      = a_after;
    res.flag_bits      = wr.flag_we ? wr.flags : flags;
    res.pair_hl_after  = {h_after, l_after};
  end

endmodule

>>> hw/rtl/cle_regfile.sv
// Architectural state: seven 8-bit registers and the four-bit flag register.
// Written from the decode write struct when an instruction executes; depends on cle_pkg.
module cle_regfile (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           exec_en,
  input  cle_pkg::wr_t   wr,
  output cle_pkg::regs_t regs,
  output logic [3:0]     flags
);

  cle_pkg::regs_t regs_r;
  logic [3:0]     flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r  <= '0;
      flags_r <= 4'h0;
    end else if (exec_en) begin
      if (wr.reg_we) regs_r[wr.reg_idx] <= wr.reg_data;
      if (wr.flag_we) flags_r <= wr.flags;
    end
  end

  assign regs  = regs_r;
  assign flags = flags_r;

endmodule

>>> hw/rtl/cpu_load_and_alu_execute_core.sv
// Top level of the load and add/subtract execute core: input register, decode, result register.
// Depends on cle_pkg, cle_if, cle_exec and cle_regfile.
//
//   Channel | Direction | Payload
//   in_ch   | in        | opcode[7:0], mem_byte[7:0]
//   out_ch  | out       | mem_write, mem_address[15:0], mem_write_data[7:0], acc_value[7:0],
//           |           | flag_bits[3:0], pair_hl_after[15:0]
//
// An item is held in the input register after its transfer and executes once the result
// register can take it, moving into that register, from which its result is offered.
// One item per cycle is sustained while out_ch is ready; the register file update and decode
// set the path. Synchronous reset clears the register file, the flags and both valid bits.
// A stalled result holds the result register; an empty input register still takes one more item.
module cpu_load_and_alu_execute_core (
  input logic      clk,
  input logic      rst_n,
  cle_in_if.sink   in_ch,
  cle_out_if.source out_ch
);

  logic               s1_valid_r;
  logic [7:0]         s1_opcode_r;
  logic [7:0]         s1_mem_r;
  logic               out_valid_r;
  cle_pkg::result_t   out_data_r;
  logic               advance;
  cle_pkg::regs_t     regs;
  logic [3:0]         flags;
  cle_pkg::wr_t       wr;
  cle_pkg::result_t   res;

  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;

  cle_exec u_exec (
    .opcode   (s1_opcode_r),
    .mem_byte (s1_mem_r),
    .regs     (regs),
    .flags    (flags),
    .wr       (wr),
    .res      (res)
  );

  cle_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .exec_en (advance),
    .wr      (wr),
    .regs    (regs),
    .flags   (flags)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) s1_valid_r <= in_ch.valid;
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_opcode_r <= in_ch.opcode;
      s1_mem_r    <= in_ch.mem_byte;
    end
    if (advance) out_data_r <= res;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.mem_write      = out_data_r.mem_write;
  assign out_ch.mem_address    = out_data_r.mem_address;
  assign out_ch.mem_write_data = out_data_r.mem_write_data;
  assign out_ch.acc_value      = out_data_r.acc_value;
  assign out_ch.flag_bits      = out_data_r.flag_bits;
  assign out_ch.pair_hl_after  = out_data_r.pair_hl_after;

endmodule

>>> verif/tb_top.sv
// Testbench for cpu_load_and_alu_execute_core: directed and random opcodes with a self-checking
// scoreboard that mirrors the register file, the flags and the memory-store behaviour.
// Depends on cle_pkg, the cle_in_if and cle_out_if interfaces and the core itself.
module tb_top;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_LEN    = 64;
  localparam int REPORT_MAX  = 10;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  cle_in_if  in_ch();
  cle_out_if out_ch();

  cpu_load_and_alu_execute_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [7:0]        cpu_regs [cle_pkg::NUM_REGS];
  logic [3:0]        cpu_flags;
  cle_pkg::result_t  pending_results [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_req = 1'b0;
  int hold_count = 0;

  int cycle_count     = 0;
  int mismatches      = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int stores_checked  = 0;
  int alu_items       = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Returns the expected result of one opcode and advances the mirrored CPU state.
  function automatic cle_pkg::result_t execute_opcode(input logic [7:0] op,
                                                      input logic [7:0] mem);
    cle_pkg::result_t res;
    logic [2:0]       src;
    logic [2:0]       dst;
    logic [7:0]       opnd;
    logic [7:0]       acc;
    logic [8:0]       total;
    logic [4:0]       nibble;
    logic             cin;
    logic [3:0]       fl;
    cle_pkg::alu_op_t kind;
    res = '0;
    res.mem_address = {cpu_regs[cle_pkg::IDX_H], cpu_regs[cle_pkg::IDX_L]};
    src = op[2:0];
    if (src == cle_pkg::OPND_MEM) begin
      opnd = mem;
    end else begin
      opnd = cpu_regs[(src == cle_pkg::OPND_A) ? cle_pkg::IDX_A : src];
    end
    if (op[7:6] == cle_pkg::GRP_LD && op != cle_pkg::OP_HALT) begin
      dst = op[5:3];
      if (dst == cle_pkg::OPND_MEM) begin
        res.mem_write = 1'b1;
        res.mem_write_data = opnd;
      end else begin
        cpu_regs[(dst == cle_pkg::OPND_A) ? cle_pkg::IDX_A : dst] = opnd;
      end
    end else if (op[7:5] == cle_pkg::GRP_ALU) begin
      kind = cle_pkg::alu_op_t'(op[4:3]);
      cin = (kind == cle_pkg::ALU_ADC || kind == cle_pkg::ALU_SBC) ? cpu_flags[0] : 1'b0;
      acc = cpu_regs[cle_pkg::IDX_A];
      if (kind == cle_pkg::ALU_ADD || kind == cle_pkg::ALU_ADC) begin
        fl = 4'h0;
        nibble = {1'b0, acc[3:0]} + {1'b0, opnd[3:0]} + {4'd0, cin};
        total = {1'b0, acc} + {1'b0, opnd} + {8'd0, cin};
      end else begin
        fl = cle_pkg::FLAG_N;
        nibble = {1'b0, acc[3:0]} - {1'b0, opnd[3:0]} - {4'd0, cin};
        total = {1'b0, acc} - {1'b0, opnd} - {8'd0, cin};
      end
      if (nibble[4]) fl = fl | cle_pkg::FLAG_H;
      if (total[8]) fl = fl | cle_pkg::FLAG_C;
      if (total[7:0] == 8'h00) fl = fl | cle_pkg::FLAG_Z;
      cpu_regs[cle_pkg::IDX_A] = total[7:0];
      cpu_flags = fl;
    end
    res.acc_value = cpu_regs[cle_pkg::IDX_A];
    res.flag_bits = cpu_flags;
    res.pair_hl_after = {cpu_regs[cle_pkg::IDX_H], cpu_regs[cle_pkg::IDX_L]};
    return res;
  endfunction

  function automatic void compare_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_MAX) begin
        $display("Result %0d, %s: expected 0x%0h, got 0x%0h", results_checked, name, want, got);
      end
    end
  endfunction

  always @(negedge clk) begin
    if (hold_req) begin
      out_ch.ready <= 1'b0;
      if (hold_count < HOLD_LEN) hold_count <= hold_count + 1;
    end else begin
      hold_count <= 0;
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    cle_pkg::result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("Result transfer with nothing outstanding, acc 0x%0h", out_ch.acc_value);
        end
      end else begin
        want = pending_results.pop_front();
        compare_field("mem_write", 16'(want.mem_write), 16'(out_ch.mem_write));
        compare_field("mem_address", want.mem_address, out_ch.mem_address);
        compare_field("mem_write_data", 16'(want.mem_write_data), 16'(out_ch.mem_write_data));
        compare_field("acc_value", 16'(want.acc_value), 16'(out_ch.acc_value));
        compare_field("flag_bits", 16'(want.flag_bits), 16'(out_ch.flag_bits));
        compare_field("pair_hl_after", want.pair_hl_after, out_ch.pair_hl_after);
        if (want.mem_write) stores_checked++;
        results_checked++;
      end
    end
  end

  task automatic send_item(input logic [7:0] op, input logic [7:0] mem);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.mem_byte <= mem;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(execute_opcode(op, mem));
    items_sent++;
    if (op[7:5] == cle_pkg::GRP_ALU) alu_items++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_opcode();
    case ($urandom_range(9))
      0, 1, 2, 3: return {cle_pkg::GRP_LD, 6'($urandom_range(63))};
      4, 5, 6, 7: return {cle_pkg::GRP_ALU, 5'($urandom_range(31))};
      8:          return cle_pkg::OP_HALT;
      default:    return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] pick_mem_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic test_register_loads();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_item(8'h7e, 8'hff);
    send_item(8'h47, 8'h00);
    send_item(8'h66, 8'h80);
    send_item(8'h6e, 8'h01);
    send_item(8'h70, 8'h00);
    send_item(8'h77, 8'h3c);
    send_item(8'h74, 8'h00);
    send_item(8'h75, 8'h00);
    send_item(cle_pkg::OP_HALT, 8'haa);
    send_item(8'h00, 8'h55);
    send_item(8'hff, 8'h55);
    send_item(8'ha0, 8'h55);
    send_item(8'h7f, 8'h00);
    send_item(8'h40, 8'h00);
    drain_results();
  endtask

  task automatic test_add_subtract();
    send_item(8'h7e, 8'hff);
    send_item(8'h86, 8'h01);
    send_item(8'h8e, 8'h0f);
    send_item(8'h96, 8'h11);
    send_item(8'h9e, 8'h00);
    send_item(8'h97, 8'h00);
    send_item(8'h80, 8'h00);
    send_item(8'h8f, 8'h00);
    send_item(8'h9f, 8'h00);
    drain_results();
  endtask

  task automatic test_random_stream(input int count, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_item(pick_opcode(), pick_mem_byte());
    drain_results();
  endtask

  // The receiver holds off long enough for the core to fill and refuse further transfers.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 20;
    hold_req = 1'b1;
    fork
      repeat (40) send_item(pick_opcode(), pick_mem_byte());
      begin
        wait (hold_count == HOLD_LEN);
        hold_req = 1'b0;
      end
    join
    drain_results();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = 8'h00;
    in_ch.mem_byte = 8'h00;
    for (int i = 0; i < cle_pkg::NUM_REGS; i++) cpu_regs[i] = 8'h00;
    cpu_flags = 4'h0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_register_loads();
    test_add_subtract();
    test_random_stream(250, 10, 54);
    test_random_stream(250, 54, 10);
    test_output_backpressure();
    test_random_stream(250, 0, 0);

    drain_results();
    repeat (6) @(posedge clk);
    if (pending_results.size() != 0) begin
      mismatches++;
      $display("%0d results never arrived", pending_results.size());
    end
    $display("Ran %0d opcodes (%0d add/subtract) and checked %0d results, %0d of them stores.",
             items_sent, alu_items, results_checked, stores_checked);
    $display("Idle patterns on both sides and a long output stall were exercised; %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
